/* rtl/core/irsw_pkg.sv */
// Shared types, constants and the carrier table for the IR pulse to SPI byte core.
// No dependencies; imported by irsw_ctrl, irsw_datapath and the top level.
package irsw_pkg;

    localparam int DUR_W       = 20;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;
    localparam int COUNT_W     = 17;
    localparam int POS_W       = 5;
    localparam int WAVE_LENGTH = 25;
    localparam int PROD_W      = 26;
    localparam int SCALE_W     = 16;
    localparam int BITS_W      = 21;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam int FULL_W      = PROD_W + RECIP_W;

    localparam logic [DUR_W-1:0]   DUR_MAX     = 20'd1000000;
    localparam logic [PROD_W-1:0]  SCALE_NUM   = 26'd38;
    // ceil(2^36 / 1000); exact floor division for products below 2^26
    localparam logic [RECIP_W-1:0] RECIP_1000  = 27'd68719477;
    localparam logic [BITS_W-1:0]  MARK_MUL    = 21'd26;
    localparam logic [BITS_W-1:0]  SPACE_MUL   = 21'd25;
    localparam logic [POS_W-1:0]   POS_LAST    = 5'(WAVE_LENGTH - 1);

    typedef enum logic [1:0] {
        STAT_LOAD    = 2'd0,
        STAT_BYTE    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_REFUSED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_REFUSE = 2'd1,
        OP_PULL   = 2'd2
    } op_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div;
        logic count;
        logic emit;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic bytes_zero;
    } dp_stat_t;

    function automatic logic [7:0] carrier_byte(input logic [POS_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            5'd0:    b = 8'h00;
            5'd1:    b = 8'h0F;
            5'd2:    b = 8'hFF;
            5'd3:    b = 8'h80;
            5'd4:    b = 8'h07;
            5'd5:    b = 8'hFF;
            5'd6:    b = 8'hC0;
            5'd7:    b = 8'h03;
            5'd8:    b = 8'hFF;
            5'd9:    b = 8'hE0;
            5'd10:   b = 8'h01;
            5'd11:   b = 8'hFF;
            5'd12:   b = 8'hF0;
            5'd13:   b = 8'h00;
            5'd14:   b = 8'hFF;
            5'd15:   b = 8'hF8;
            5'd16:   b = 8'h00;
            5'd17:   b = 8'h7F;
            5'd18:   b = 8'hFC;
            5'd19:   b = 8'h00;
            5'd20:   b = 8'h3F;
            5'd21:   b = 8'hFE;
            5'd22:   b = 8'h00;
            5'd23:   b = 8'h1F;
            5'd24:   b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/core/ir_pulse_to_spi_wave_bytes_core.sv */
// IR mark/space durations to SPI carrier bytes; one input beat at a time.
// Pull, or a refused load: emit step raises tvalid; no new beat taken until done.
// Load: saturate and times 38, divide by 1000 (reciprocal multiply), byte count;
// tvalid rises after the mul, div, count and emit steps; no new beat until then.
// A stalled result beat holds the sequencer in its emit step.
// Synchronous active-low reset clears the entry state; nothing is pending after it.
module ir_pulse_to_spi_wave_bytes_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] duration_us, [23:20] zero
    input  logic [1:0]  s_axis_tuser,   // [0] action, [1] first_entry
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // last_of_entry
);
    import irsw_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    irsw_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .action        (s_axis_tuser[0]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .dp_stat       (dp_stat),
        .dp_cmd        (dp_cmd)
    );

    irsw_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat),
        .s_tdata (s_axis_tdata),
        .s_tuser (s_axis_tuser),
        .m_tdata (m_axis_tdata),
        .m_tuser (m_axis_tuser),
        .m_tlast (m_axis_tlast)
    );

    // only byte beats carry data or an end-of-entry mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser != STAT_BYTE))
            |-> (m_axis_tdata == 8'h00 && !m_axis_tlast))
        else $error("non-byte result carries data or tlast");

    // one item in flight: no new accept right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // a result appears only out of the busy phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised without an item in progress");

endmodule

/* rtl/core/irsw_ctrl.sv */
// Sequencer for the IR pulse to SPI byte core: handshakes and datapath commands.
// Depends on irsw_pkg.
module irsw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic              action,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  irsw_pkg::dp_stat_t dp_stat,
    output irsw_pkg::dp_cmd_t  dp_cmd
);
    import irsw_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_COUNT = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   slot_free;
    logic   emit_fire;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign emit_fire     = (state_reg == ST_EMIT) && slot_free;
    assign m_axis_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (action) begin
                        op_next    = OP_PULL;
                        state_next = ST_EMIT;
                    end else if (!dp_stat.bytes_zero) begin
                        op_next    = OP_REFUSE;
                        state_next = ST_EMIT;
                    end else begin
                        op_next    = OP_LOAD;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   state_next = ST_COUNT;
            ST_COUNT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        dp_cmd.capture = accept;
        dp_cmd.mul     = (state_reg == ST_MUL);
        dp_cmd.div     = (state_reg == ST_DIV);
        dp_cmd.count   = (state_reg == ST_COUNT);
        dp_cmd.emit    = emit_fire;
        dp_cmd.op      = op_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/core/irsw_datapath.sv */
// Datapath for the IR pulse to SPI byte core: duration scaling, byte counts,
// entry state and the output beat register. Depends on irsw_pkg.
module irsw_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  irsw_pkg::dp_cmd_t                   dp_cmd,
    output irsw_pkg::dp_stat_t                  dp_stat,
    input  logic [irsw_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [irsw_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic [irsw_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [irsw_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast
);
    import irsw_pkg::*;

    logic [DUR_W-1:0]   dur_reg;
    logic               first_reg;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [COUNT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [POS_W-1:0]   wave_pos_reg, wave_pos_next;
    logic               emitting_space_reg, emitting_space_next;
    logic               next_is_space_reg, next_is_space_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    status_t            out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic [DUR_W-1:0]   dur_sat;
    logic [FULL_W-1:0]  full_prod;
    logic               is_mark;
    logic [BITS_W-1:0]  mark_bits;
    logic [BITS_W-1:0]  mark_bits_m1;
    logic [BITS_W-1:0]  space_bits;
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   pos_inc;

    assign dp_stat.bytes_zero = (bytes_left_reg == '0);

    // scale stage 1: saturate, times 38
    assign dur_sat   = (dur_reg > DUR_MAX) ? DUR_MAX : dur_reg;
    assign prod_next = {{(PROD_W-DUR_W){1'b0}}, dur_sat} * SCALE_NUM;

    // scale stage 2: divide by 1000 through the reciprocal
    assign full_prod  = {{RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RECIP_1000};
    assign scale_next = full_prod[RECIP_SHIFT +: SCALE_W];

    // byte counts; a nonzero scale covers both the mark and space thresholds
    assign is_mark      = first_reg || !next_is_space_reg;
    assign mark_bits    = {{(BITS_W-SCALE_W){1'b0}}, scale_reg} * MARK_MUL;
    assign mark_bits_m1 = mark_bits - 21'd1;
    assign space_bits   = {{(BITS_W-SCALE_W){1'b0}}, scale_reg} * SPACE_MUL;

    always_comb begin
        count = '0;
        if (scale_reg != '0) begin
            if (is_mark) begin
                count = mark_bits_m1[3 +: COUNT_W];
            end else begin
                count = space_bits[3 +: COUNT_W] + 17'd1;
            end
        end
    end

    assign pos_inc = (wave_pos_reg == POS_LAST) ? '0 : wave_pos_reg + 5'd1;

    always_comb begin
        bytes_left_next     = bytes_left_reg;
        wave_pos_next       = wave_pos_reg;
        emitting_space_next = emitting_space_reg;
        next_is_space_next  = next_is_space_reg;
        out_byte_next       = out_byte_reg;
        out_status_next     = out_status_reg;
        out_last_next       = out_last_reg;

        if (dp_cmd.count) begin
            bytes_left_next     = count;
            emitting_space_next = !is_mark;
            next_is_space_next  = is_mark;
            if (is_mark) begin
                wave_pos_next = '0;
            end
        end

        if (dp_cmd.emit) begin
            out_byte_next = 8'h00;
            out_last_next = 1'b0;
            case (dp_cmd.op)
                OP_LOAD:   out_status_next = STAT_LOAD;
                OP_REFUSE: out_status_next = STAT_REFUSED;
                OP_PULL: begin
                    if (bytes_left_reg == '0) begin
                        out_status_next = STAT_EMPTY;
                    end else begin
                        out_status_next = STAT_BYTE;
                        out_byte_next   = emitting_space_reg ? 8'h00
                                                             : carrier_byte(wave_pos_reg);
                        out_last_next   = (bytes_left_reg == 17'd1);
                        bytes_left_next = bytes_left_reg - 17'd1;
                        wave_pos_next   = pos_inc;
                    end
                end
                default:   out_status_next = STAT_EMPTY;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg     <= '0;
            wave_pos_reg       <= '0;
            emitting_space_reg <= 1'b0;
            next_is_space_reg  <= 1'b0;
        end else begin
            bytes_left_reg     <= bytes_left_next;
            wave_pos_reg       <= wave_pos_next;
            emitting_space_reg <= emitting_space_next;
            next_is_space_reg  <= next_is_space_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            dur_reg   <= s_tdata[DUR_W-1:0];
            first_reg <= s_tuser[1];
        end
        if (dp_cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (dp_cmd.div) begin
            scale_reg <= scale_next;
        end
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tdata = out_byte_reg;
    assign m_tuser = out_status_reg;
    assign m_tlast = out_last_reg;

endmodule
